// ===== rtl/core/rmj_pkg.sv =====
// Shared constants and types for the radar measurement Jacobian pipeline.
package rmj_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int WORD_W     = 32;
	localparam int SQ_W       = 2 * WORD_W;
	localparam int PROD_W     = WORD_W + SQ_W;
	localparam int NUM_W      = 4 * WORD_W;
	localparam int DEN_W      = PROD_W;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int DIV_STEPS  = WORD_W;
	localparam int DIV_LAT    = DIV_STEPS + 2;
	localparam int N_DIV      = 6;

	localparam logic [WORD_W-1:0] LIMIT_RESET = 32'd429497;
	localparam logic [WORD_W-1:0] SAT_POS     = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] SAT_NEG_MAG = 32'h8000_0000;

	// Jacobian entry lanes
	localparam int J_RANGE_DX   = 0;
	localparam int J_RANGE_DY   = 1;
	localparam int J_BEARING_DX = 2;
	localparam int J_BEARING_DY = 3;
	localparam int J_RATE_DX    = 4;
	localparam int J_RATE_DY    = 5;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic [WORD_W-1:0] ax;
		logic [WORD_W-1:0] ay;
		logic              nx;
		logic              ny;
		logic              nd;
		logic [SQ_W-1:0]   c;
		logic [SQ_W-1:0]   dmag;
		logic              too_close;
	} job_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
	} div_in_t;

endpackage

// ===== rtl/core/rmj_state_if.sv =====
// Input channel: one tracked state word.
interface rmj_state_if;
	logic                valid;
	logic                ready;
	rmj_pkg::word_t      pos_x;
	rmj_pkg::word_t      pos_y;
	rmj_pkg::word_t      vel_x;
	rmj_pkg::word_t      vel_y;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

// ===== rtl/core/rmj_jac_if.sv =====
// Output channel: one Jacobian word.
interface rmj_jac_if;
	logic                valid;
	logic                ready;
	rmj_pkg::word_t      range_dx;
	rmj_pkg::word_t      range_dy;
	rmj_pkg::word_t      bearing_dx;
	rmj_pkg::word_t      bearing_dy;
	rmj_pkg::word_t      rate_dx;
	rmj_pkg::word_t      rate_dy;
	logic                too_close;

	modport source (output valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx,
		rate_dy, too_close, input ready);
	modport sink (input valid, range_dx, range_dy, bearing_dx, bearing_dy, rate_dx,
		rate_dy, too_close, output ready);
endinterface

// ===== rtl/core/rmj_front.sv =====
// Front stages: magnitudes, squared range, cross term and near-zero test.
module rmj_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  rmj_pkg::word_t             px,
	input  rmj_pkg::word_t             py,
	input  rmj_pkg::word_t             vx,
	input  rmj_pkg::word_t             vy,
	input  logic [rmj_pkg::WORD_W-1:0] limit,
	output logic                       out_valid,
	output rmj_pkg::job_t              job
);
	import rmj_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [WORD_W-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3;
	word_t px_s1, py_s1, vx_s1, vy_s1;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, c_s3;
	logic signed [SQ_W-1:0] pa_s2, pb_s2;
	logic signed [SQ_W:0] d_s3;
	job_t job_s4;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: take magnitudes of position
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= px[WORD_W-1];
			ny_s1 <= py[WORD_W-1];
			ax_s1 <= px[WORD_W-1] ? (~px + 1'b1) : px;
			ay_s1 <= py[WORD_W-1] ? (~py + 1'b1) : py;
			px_s1 <= px;
			py_s1 <= py;
			vx_s1 <= vx;
			vy_s1 <= vy;
		end
	end

	// stage 2: squares and cross products
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
			pa_s2  <= vx_s1 * py_s1;
			pb_s2  <= vy_s1 * px_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
		end
	end

	// stage 3: squared range and cross term
	always_ff @(posedge clk) begin
		if (en) begin
			c_s3  <= sqx_s2 + sqy_s2;
			d_s3  <= (SQ_W+1)'(pa_s2) - (SQ_W+1)'(pb_s2);
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
		end
	end

	// stage 4: cross term magnitude and near-zero test
	always_ff @(posedge clk) begin
		if (en) begin
			job_s4.ax        <= ax_s3;
			job_s4.ay        <= ay_s3;
			job_s4.nx        <= nx_s3;
			job_s4.ny        <= ny_s3;
			job_s4.nd        <= d_s3[SQ_W];
			job_s4.c         <= c_s3;
			job_s4.dmag      <= d_s3[SQ_W] ? SQ_W'(~d_s3 + 1'b1) : SQ_W'(d_s3);
			job_s4.too_close <= (c_s3 < SQ_W'(limit)) || (c_s3 == '0);
		end
	end

	assign out_valid = v_s4;
	assign job       = job_s4;
endmodule

// ===== rtl/core/rmj_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module rmj_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  rmj_pkg::job_t              job_in,
	output logic                       out_valid,
	output rmj_pkg::job_t              job_out,
	output logic [rmj_pkg::WORD_W-1:0] root
);
	import rmj_pkg::*;

	logic            v_s   [SQRT_STEPS];
	logic [SQ_W-1:0] rem_s [SQRT_STEPS];
	logic [SQ_W-1:0] res_s [SQRT_STEPS];
	job_t            job_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic            v_i;
		logic [SQ_W-1:0] rem_i, res_i, trial;
		job_t            job_i;

		if (k == 0) begin : g_first
			assign v_i   = in_valid;
			assign rem_i = job_in.c;
			assign res_i = '0;
			assign job_i = job_in;
		end else begin : g_next
			assign v_i   = v_s[k-1];
			assign rem_i = rem_s[k-1];
			assign res_i = res_s[k-1];
			assign job_i = job_s[k-1];
		end

		assign trial = res_i + STEP_BIT;

		// advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		// try one root bit
		always_ff @(posedge clk) begin
			if (en) begin
				job_s[k] <= job_i;
				if (rem_i >= trial) begin
					rem_s[k] <= rem_i - trial;
					res_s[k] <= (res_i >> 1) + STEP_BIT;
				end else begin
					rem_s[k] <= rem_i;
					res_s[k] <= res_i >> 1;
				end
			end
		end
	end

	assign out_valid = v_s[SQRT_STEPS-1];
	assign job_out   = job_s[SQRT_STEPS-1];
	assign root      = res_s[SQRT_STEPS-1][WORD_W-1:0];
endmodule

// ===== rtl/core/rmj_prep.sv =====
// Wide products and divider operand setup for the six Jacobian entries.
module rmj_prep (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  rmj_pkg::job_t              job,
	input  logic [rmj_pkg::WORD_W-1:0] root,
	output logic                       out_valid,
	output logic                       too_close,
	output rmj_pkg::div_in_t           dv [rmj_pkg::N_DIV]
);
	import rmj_pkg::*;

	logic v_s1, v_s2;
	logic [SQ_W-1:0] pcl_s1, pch_s1, pyl_s1, pyh_s1, pxl_s1, pxh_s1;
	job_t job_s1;
	logic [WORD_W-1:0] root_s1;
	logic [PROD_W-1:0] cr, ayd, axd;
	div_in_t dv_c [N_DIV];
	div_in_t dv_s2 [N_DIV];
	logic tc_s2;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// stage 1: 32x32 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pcl_s1  <= job.c[WORD_W-1:0] * root;
			pch_s1  <= job.c[SQ_W-1:WORD_W] * root;
			pyl_s1  <= job.ay * job.dmag[WORD_W-1:0];
			pyh_s1  <= job.ay * job.dmag[SQ_W-1:WORD_W];
			pxl_s1  <= job.ax * job.dmag[WORD_W-1:0];
			pxh_s1  <= job.ax * job.dmag[SQ_W-1:WORD_W];
			job_s1  <= job;
			root_s1 <= root;
		end
	end

	// merge partial products
	assign cr  = (PROD_W'(pch_s1) << WORD_W) + PROD_W'(pcl_s1);
	assign ayd = (PROD_W'(pyh_s1) << WORD_W) + PROD_W'(pyl_s1);
	assign axd = (PROD_W'(pxh_s1) << WORD_W) + PROD_W'(pxl_s1);

	// build operands; refused states divide zero by one
	always_comb begin
		dv_c[J_RANGE_DX]   = '{NUM_W'(job_s1.ax) << FRAC_BITS, DEN_W'(root_s1), job_s1.nx};
		dv_c[J_RANGE_DY]   = '{NUM_W'(job_s1.ay) << FRAC_BITS, DEN_W'(root_s1), job_s1.ny};
		dv_c[J_BEARING_DX] = '{NUM_W'(job_s1.ay) << (2 * FRAC_BITS), DEN_W'(job_s1.c),
			!job_s1.ny};
		dv_c[J_BEARING_DY] = '{NUM_W'(job_s1.ax) << (2 * FRAC_BITS), DEN_W'(job_s1.c),
			job_s1.nx};
		dv_c[J_RATE_DX]    = '{NUM_W'(ayd) << FRAC_BITS, cr, job_s1.ny ^ job_s1.nd};
		dv_c[J_RATE_DY]    = '{NUM_W'(axd) << FRAC_BITS, cr, !(job_s1.nx ^ job_s1.nd)};
		if (job_s1.too_close) begin
			for (int i = 0; i < N_DIV; i++) begin
				dv_c[i].num = '0;
				dv_c[i].den = DEN_W'(1);
			end
		end
	end

	// stage 2: hold operands
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s2 <= dv_c;
			tc_s2 <= job_s1.too_close;
		end
	end

	assign out_valid = v_s2;
	assign too_close = tc_s2;
	assign dv        = dv_s2;
endmodule

// ===== rtl/core/rmj_div.sv =====
// Pipelined restoring divider with 32-bit signed saturated quotient.
module rmj_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  rmj_pkg::div_in_t d_in,
	output logic             out_valid,
	output rmj_pkg::word_t   quo
);
	import rmj_pkg::*;

	logic              v_s0;
	logic [DEN_W-1:0]  rem_s0, den_s0;
	logic [WORD_W-1:0] lo_s0;
	logic              ovf_s0, neg_s0;

	logic              v_s   [DIV_STEPS];
	logic [DEN_W-1:0]  rem_s [DIV_STEPS];
	logic [DEN_W-1:0]  den_s [DIV_STEPS];
	logic [WORD_W-1:0] lo_s  [DIV_STEPS];
	logic [WORD_W-1:0] q_s   [DIV_STEPS];
	logic              ovf_s [DIV_STEPS];
	logic              neg_s [DIV_STEPS];

	logic              v_sf;
	word_t             quo_sf;
	logic [WORD_W-1:0] q_l, mag;
	logic              ovf_l, neg_l;

	// entry stage: split numerator, flag quotients of 2^32 or more
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s0 <= d_in.num[NUM_W-1:WORD_W];
			lo_s0  <= d_in.num[WORD_W-1:0];
			den_s0 <= d_in.den;
			neg_s0 <= d_in.neg;
			ovf_s0 <= d_in.num[NUM_W-1:WORD_W] >= d_in.den;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic              v_i, ovf_i, neg_i, ge;
		logic [DEN_W-1:0]  rem_i, den_i;
		logic [WORD_W-1:0] lo_i, q_i;
		logic [DEN_W:0]    t;

		if (k == 0) begin : g_first
			assign v_i   = v_s0;
			assign rem_i = rem_s0;
			assign den_i = den_s0;
			assign lo_i  = lo_s0;
			assign q_i   = '0;
			assign ovf_i = ovf_s0;
			assign neg_i = neg_s0;
		end else begin : g_next
			assign v_i   = v_s[k-1];
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign lo_i  = lo_s[k-1];
			assign q_i   = q_s[k-1];
			assign ovf_i = ovf_s[k-1];
			assign neg_i = neg_s[k-1];
		end

		assign t  = {rem_i, lo_i[WORD_W-1]};
		assign ge = t >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		// shift in one numerator bit, subtract when it fits
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DEN_W'(t - {1'b0, den_i}) : t[DEN_W-1:0];
				q_s[k]   <= {q_i[WORD_W-2:0], ge};
				lo_s[k]  <= lo_i << 1;
				den_s[k] <= den_i;
				ovf_s[k] <= ovf_i;
				neg_s[k] <= neg_i;
			end
		end
	end

	assign q_l   = q_s[DIV_STEPS-1];
	assign ovf_l = ovf_s[DIV_STEPS-1];
	assign neg_l = neg_s[DIV_STEPS-1];

	// apply sign and saturate
	always_comb begin
		if (neg_l) begin
			mag = (ovf_l || q_l > SAT_NEG_MAG) ? SAT_NEG_MAG : q_l;
		end else begin
			mag = (ovf_l || q_l > SAT_POS) ? SAT_POS : q_l;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en) begin
			v_sf <= v_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_sf <= neg_l ? word_t'(~mag + 1'b1) : word_t'(mag);
		end
	end

	assign out_valid = v_sf;
	assign quo       = quo_sf;
endmodule

// ===== rtl/core/radar_measurement_jacobian.sv =====
// Radar measurement Jacobian pipeline: range, bearing and range-rate partials.
//
// Takes one state word (pos_x, pos_y, vel_x, vel_y, signed Q16.16) per cycle and
// returns the six distinct Jacobian entries, each truncated toward zero and
// saturated to 32 bits. When the squared range (Q32.32) is zero or below
// near_zero_limit, every entry is zero and too_close is set. The pipe is built from
// 4 front stages, a 32-stage square root, 2 product stages and 34
// divider stages (one quotient bit per stage, six dividers side by side). Words
// enter every cycle; the whole pipe holds only when the output word is not taken.
// Write near_zero_limit only while the pipe is empty.
module radar_measurement_jacobian (
	input  logic                       clk,
	input  logic                       arst_n,
	rmj_state_if.sink                  state,
	rmj_jac_if.source                  jac,
	input  logic                       cfg_we,
	input  logic [rmj_pkg::WORD_W-1:0] cfg_wdata
);
	import rmj_pkg::*;

	logic              en;
	logic [WORD_W-1:0] limit_q;
	logic              fr_v, sq_v, pr_v, pr_tc;
	job_t              fr_job, sq_job;
	logic [WORD_W-1:0] sq_root;
	div_in_t           pr_dv [N_DIV];
	logic [N_DIV-1:0]  div_v;
	word_t             div_q [N_DIV];
	logic              tc_s [DIV_LAT];

	// hold the whole pipe while the output word waits
	assign en          = !jac.valid || jac.ready;
	assign state.ready = en;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	rmj_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (state.valid),
		.px        (state.pos_x),
		.py        (state.pos_y),
		.vx        (state.vel_x),
		.vy        (state.vel_y),
		.limit     (limit_q),
		.out_valid (fr_v),
		.job       (fr_job)
	);

	rmj_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_v),
		.job_in    (fr_job),
		.out_valid (sq_v),
		.job_out   (sq_job),
		.root      (sq_root)
	);

	rmj_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.job       (sq_job),
		.root      (sq_root),
		.out_valid (pr_v),
		.too_close (pr_tc),
		.dv        (pr_dv)
	);

	for (genvar i = 0; i < N_DIV; i++) begin : g_div
		rmj_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (pr_v),
			.d_in      (pr_dv[i]),
			.out_valid (div_v[i]),
			.quo       (div_q[i])
		);
	end

	// carry the near-zero flag alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			tc_s[0] <= pr_tc;
			for (int i = 1; i < DIV_LAT; i++) begin
				tc_s[i] <= tc_s[i-1];
			end
		end
	end

	assign jac.valid      = div_v[0];
	assign jac.range_dx   = div_q[J_RANGE_DX];
	assign jac.range_dy   = div_q[J_RANGE_DY];
	assign jac.bearing_dx = div_q[J_BEARING_DX];
	assign jac.bearing_dy = div_q[J_BEARING_DY];
	assign jac.rate_dx    = div_q[J_RATE_DX];
	assign jac.rate_dy    = div_q[J_RATE_DY];
	assign jac.too_close  = tc_s[DIV_LAT-1];

	// dividers stay in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_v == {N_DIV{div_v[0]}})
		else $error("divider valid bits disagree");

	// a refused state gives an all-zero matrix
	a_near_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(jac.valid && jac.too_close) |-> (jac.range_dx == 0 && jac.range_dy == 0 &&
		jac.bearing_dx == 0 && jac.bearing_dy == 0 && jac.rate_dx == 0 &&
		jac.rate_dy == 0))
		else $error("nonzero entry with too_close set");

	// px over range never exceeds one in magnitude
	a_range_unit: assert property (@(posedge clk) disable iff (!arst_n)
		jac.valid |-> (jac.range_dx <= (32'sd1 <<< FRAC_BITS) &&
		jac.range_dx >= -(32'sd1 <<< FRAC_BITS)))
		else $error("range_dx beyond unit magnitude");
endmodule

// ===== test/radar_measurement_jacobian_test.sv =====
// Self-checking testbench for the radar measurement Jacobian pipeline.
module radar_measurement_jacobian_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rmj_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int DRAIN_CYCLES = 90;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AT = 300;
	localparam int PHASE_ITEMS = 240;

	typedef struct packed {
		word_t px;
		word_t py;
		word_t vx;
		word_t vy;
	} track_t;

	typedef struct packed {
		word_t range_dx;
		word_t range_dy;
		word_t bearing_dx;
		word_t bearing_dy;
		word_t rate_dx;
		word_t rate_dy;
		logic  too_close;
	} jacobian_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [WORD_W-1:0] cfg_wdata;

	rmj_state_if st();
	rmj_jac_if jac();

	radar_measurement_jacobian dut (
		.clk(clk),
		.arst_n(arst_n),
		.state(st),
		.jac(jac),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	track_t tracks_pending[$];
	jacobian_t jacobians_due[$];
	logic [WORD_W-1:0] near_limit = LIMIT_RESET;
	logic state_taken = 1'b0;
	logic calm = 1'b0;
	int err_count = 0;
	int tracks_in = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	always #(HALF_PERIOD) clk = ~clk;

	// Integer square root, floor, bit by bit
	function automatic logic [63:0] floor_sqrt(logic [63:0] c);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > c)
			b = b >> 2;
		while (b != 0) begin
			if (c >= res + b) begin
				c = c - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Signed quotient, truncated toward zero, saturated to 32 bits
	function automatic word_t sat_quotient(logic neg, logic [127:0] num, logic [127:0] den);
		logic [127:0] q;
		logic [31:0] lo;
		if (den == 0)
			return '0;
		q = num / den;
		lo = q[31:0];
		if (neg)
			return (q > 128'h8000_0000) ? word_t'(SAT_NEG_MAG) : word_t'(-lo);
		return (q > 128'h7FFF_FFFF) ? word_t'(SAT_POS) : word_t'(lo);
	endfunction

	function automatic jacobian_t predict_jacobian(track_t t, logic [31:0] limit);
		logic nx, ny, nd;
		logic [63:0] ax, ay, c, r, dmag;
		logic signed [63:0] d;
		logic [127:0] cr;
		jacobian_t j;
		j = '0;
		nx = t.px[31];
		ny = t.py[31];
		ax = {32'd0, nx ? (~t.px + 32'd1) : t.px};
		ay = {32'd0, ny ? (~t.py + 32'd1) : t.py};
		c = ax * ax + ay * ay;
		if (c < {32'd0, limit} || c == 0) begin
			j.too_close = 1'b1;
			return j;
		end
		r = floor_sqrt(c);
		d = longint'(t.vx) * longint'(t.py) - longint'(t.vy) * longint'(t.px);
		nd = d < 0;
		dmag = nd ? 64'(-d) : 64'(d);
		cr = 128'(c) * 128'(r);
		j.range_dx = sat_quotient(nx, 128'(ax) << FRAC_BITS, 128'(r));
		j.range_dy = sat_quotient(ny, 128'(ay) << FRAC_BITS, 128'(r));
		j.bearing_dx = sat_quotient(!ny, 128'(ay) << (2 * FRAC_BITS), 128'(c));
		j.bearing_dy = sat_quotient(nx, 128'(ax) << (2 * FRAC_BITS), 128'(c));
		j.rate_dx = sat_quotient(ny != nd, (128'(ay) * 128'(dmag)) << FRAC_BITS, cr);
		j.rate_dy = sat_quotient(nx == nd, (128'(ax) * 128'(dmag)) << FRAC_BITS, cr);
		return j;
	endfunction

	task automatic report_mismatch(string field, word_t got, word_t want);
		$display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want);
		err_count++;
	endtask

	// Drive state words; hold a word until it is taken
	always @(negedge clk) begin
		track_t t;
		if (arst_n && (!st.valid || state_taken)) begin
			if (tracks_pending.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
				t = tracks_pending.pop_front();
				st.valid <= 1'b1;
				st.pos_x <= t.px;
				st.pos_y <= t.py;
				st.vel_x <= t.vx;
				st.vel_y <= t.vy;
			end else begin
				st.valid <= 1'b0;
			end
		end
	end

	// Drive ready for Jacobian words, with one long hold-off to back up the pipe
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && tracks_in >= HOLD_OFF_AT) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				jac.ready <= 1'b0;
			end else begin
				jac.ready <= calm || ($urandom_range(0, 99) >= 24);
			end
		end
	end

	// Check Jacobian words, predict accepted state words, watch for a hang
	always @(posedge clk) begin
		jacobian_t want;
		track_t t;
		if (arst_n) begin
			if (jac.valid && jac.ready) begin
				if (jacobians_due.size() == 0) begin
					$display("[%0t] Jacobian word with nothing expected", $time);
					err_count++;
				end else begin
					want = jacobians_due.pop_front();
					if (jac.range_dx !== want.range_dx)
						report_mismatch("range_dx", jac.range_dx, want.range_dx);
					if (jac.range_dy !== want.range_dy)
						report_mismatch("range_dy", jac.range_dy, want.range_dy);
					if (jac.bearing_dx !== want.bearing_dx)
						report_mismatch("bearing_dx", jac.bearing_dx, want.bearing_dx);
					if (jac.bearing_dy !== want.bearing_dy)
						report_mismatch("bearing_dy", jac.bearing_dy, want.bearing_dy);
					if (jac.rate_dx !== want.rate_dx)
						report_mismatch("rate_dx", jac.rate_dx, want.rate_dx);
					if (jac.rate_dy !== want.rate_dy)
						report_mismatch("rate_dy", jac.rate_dy, want.rate_dy);
					if (jac.too_close !== want.too_close)
						report_mismatch("too_close", word_t'(jac.too_close),
							word_t'(want.too_close));
				end
			end
			state_taken <= st.valid && st.ready;
			if (st.valid && st.ready) begin
				t = '{st.pos_x, st.pos_y, st.vel_x, st.vel_y};
				jacobians_due.push_back(predict_jacobian(t, near_limit));
				tracks_in++;
			end
			if ((st.valid && st.ready) || (jac.valid && jac.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Random field value from a mix of magnitude classes
	function automatic word_t rand_word();
		case ($urandom_range(0, 4))
			0: return word_t'($urandom);
			1: return word_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			2: return word_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
			3: begin
				case ($urandom_range(0, 4))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			default: return word_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		endcase
	endfunction

	task automatic add_track(word_t px, word_t py, word_t vx, word_t vy);
		tracks_pending.push_back('{px, py, vx, vy});
	endtask

	task automatic add_random(int n);
		repeat (n)
			add_track(rand_word(), rand_word(), rand_word(), rand_word());
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (tracks_pending.size() > 0 || st.valid || jacobians_due.size() > 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(logic [WORD_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		near_limit = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		st.valid = 1'b0;
		st.pos_x = '0;
		st.pos_y = '0;
		st.vel_x = '0;
		st.vel_y = '0;
		jac.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: origin, limit edges, extreme fields, saturation
		add_track(0, 0, 0, 0);
		add_track(655, 0, 1, 1);
		add_track(656, 0, 32'sh0001_0000, -32'sh0001_0000);
		add_track(0, -656, 5, 7);
		add_track(-656, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		add_track(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		add_track(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		add_track(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
		add_track(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		add_track(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		add_track(32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000, -32'sh0002_0000);
		add_track(-32'sh0003_0000, 32'sh0004_0000, -32'sh0001_0000, 32'sh0002_0000);
		add_track(32'sh0001_0000, 0, 32'sh0001_0000, -32'sh0001_0000);
		add_track(1000, -1000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		add_track(-1000, 1000, 32'sh8000_0000, 32'sh8000_0000);
		add_track(-1, -1, -1, -1);
		add_track(32'sh0100_0000, 32'sh0100_0000, 0, 0);
		add_random(PHASE_ITEMS);
		drain();

		// Limit zero: only an exact zero range is too close
		write_limit(32'd0);
		add_track(0, 0, 3, 4);
		add_track(1, 0, 3, 4);
		add_track(0, -1, 32'sh7FFF_FFFF, 32'sh8000_0000);
		calm = 1'b1;
		add_random(PHASE_ITEMS);
		drain();
		calm = 1'b0;

		// Largest limit, just under 1.0 squared
		write_limit(32'hFFFF_FFFF);
		add_track(32'sh0001_0000, 0, 1, 1);
		add_track(32'sh0000_FFFF, 0, 1, 1);
		add_random(PHASE_ITEMS);
		drain();

		write_limit($urandom);
		add_random(PHASE_ITEMS);
		drain();

		write_limit(LIMIT_RESET);
		add_random(PHASE_ITEMS);
		drain();

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/rmj_pkg.sv
rtl/core/rmj_state_if.sv
rtl/core/rmj_jac_if.sv
rtl/core/rmj_front.sv
rtl/core/rmj_sqrt.sv
rtl/core/rmj_prep.sv
rtl/core/rmj_div.sv
rtl/core/radar_measurement_jacobian.sv
test/radar_measurement_jacobian_test.sv
